@@ design/grt_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the grid ray traversal core
// no dependencies

package grt_pkg;

	// register indexes of the configuration port
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_CELL_SIZE = 1'b1;

	// radicand of the length is 68 bits, two bits retired per root step
	localparam int ROOT_STEPS = 34;
	localparam int ROOT_W     = 34;

	typedef enum logic [1:0] {
		REASON_OBST = 2'd0,
		REASON_LEFT = 2'd1,
		REASON_END  = 2'd2
	} stop_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_ROOT,
		S_PINIT,
		S_PX,
		S_QY,
		S_CHECK,
		S_TEST,
		S_SCALE,
		S_DIV,
		S_CSINIT,
		S_CSMUL,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_MAPWR,
		OP_LOAD,
		OP_MUL,
		OP_LDDY,
		OP_ROOTINIT,
		OP_ROOT,
		OP_PINIT,
		OP_QINIT,
		OP_QSAVE,
		OP_READ,
		OP_STEP,
		OP_STOP,
		OP_DIVINIT,
		OP_DIV,
		OP_CSINIT,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t   op;
		stop_t reason;
	} cmd_t;

	typedef struct packed {
		logic mb_zero;
		logic cnt_last;
		logic outside;
		logic obstacle;
		logic at_end;
	} status_t;

endpackage

@@ design/grid_ray_traversal_core.sv @@
`timescale 1ns / 1ps
// Grid ray traversal core. Input transactions either write one occupancy cell
// (mode 0) or trace one ray (mode 1); a trace gives one result transaction.
// Map writes produce nothing. A trace runs through:
//   setup, dx^2 and dy^2 on the shift-add multiplier, 34 root steps for the
//   ray length, two setup products, one grid ram read per cell walked, then
//   tnum*len, one divide step per quotient bit, the cell size product and a
//   load of the output register.
// A ray across the 256x256 map visits up to about 512 cells; one trace is in
// flight at a time.
// in_ready is high only between traces. A finished result sits in the output
// register until taken; a stalled receiver blocks only the next trace's end.
// Reset sets occupancy_threshold to 50 and cell_size to 3277 and empties the
// output. Grid contents are undefined until written; no clearing pass runs.
// Config writes (cfg_write, cfg_index, cfg_data) apply at once; the user is to
// make them only when idle, and the block itself leaves this unenforced.

module grid_ray_traversal_core #(
	parameter int GRID_WIDTH = 256,
	parameter int GRID_HEIGHT = 256,
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [7:0]         cell_x,
	input  logic [7:0]         cell_y,
	input  logic signed [7:0]  cell_value,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        distance,
	output logic [1:0]         stop_reason
);
	import grt_pkg::*;

	localparam int GAW = $clog2(GRID_WIDTH * GRID_HEIGHT);

	cmd_t           cmd;
	status_t        status;
	logic           ram_we, ram_re;
	logic [GAW-1:0] ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	grt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_mode  (mode),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	grt_dp #(
		.GRID_WIDTH   (GRID_WIDTH),
		.GRID_HEIGHT  (GRID_HEIGHT),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_value (cell_value),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.distance   (distance),
		.stop_reason(stop_reason),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	grt_ram #(
		.WIDTH(8),
		.DEPTH(GRID_WIDTH * GRID_HEIGHT)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	// a trace transaction closes the input until its result is built
	a_trace_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode) |=> !in_ready)
		else $error("input open right after trace");

	// grid reads only land inside the map
	a_read_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (int'(ram_raddr) < GRID_WIDTH * GRID_HEIGHT))
		else $error("grid read outside map");

	// map writes only happen while idle and never together with a walk read
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (in_ready && !ram_re))
		else $error("grid write while busy");

	a_reason_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stop_reason == REASON_OBST || stop_reason == REASON_LEFT
		               || stop_reason == REASON_END))
		else $error("bad stop reason");
`endif

endmodule

@@ design/grt_ram.sv @@
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module grt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/grt_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for the grid ray traversal core
// depends on grt_pkg

module grt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_mode,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  grt_pkg::status_t status,
	output grt_pkg::cmd_t    cmd
);
	import grt_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load_out;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_mode) state_d = S_SQX;
			end
			S_SQX: begin
				if (status.mb_zero) state_d = S_SQY;
			end
			S_SQY: begin
				if (status.mb_zero) state_d = S_ROOT;
			end
			S_ROOT: begin
				if (status.cnt_last) state_d = S_PINIT;
			end
			S_PINIT: state_d = S_PX;
			S_PX: begin
				if (status.mb_zero) state_d = S_QY;
			end
			S_QY: begin
				if (status.mb_zero) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (status.outside) state_d = S_SCALE;
				else state_d = S_TEST;
			end
			S_TEST: begin
				if (status.obstacle || status.at_end) state_d = S_SCALE;
				else state_d = S_CHECK;
			end
			S_SCALE: begin
				if (status.mb_zero) state_d = S_DIV;
			end
			S_DIV: begin
				if (status.cnt_last) state_d = S_CSINIT;
			end
			S_CSINIT: state_d = S_CSMUL;
			S_CSMUL: begin
				if (status.mb_zero) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.reason = REASON_LEFT;
		in_ready   = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = in_mode ? OP_LOAD : OP_MAPWR;
			end
			S_SQX: cmd.op = status.mb_zero ? OP_LDDY : OP_MUL;
			S_SQY: cmd.op = status.mb_zero ? OP_ROOTINIT : OP_MUL;
			S_ROOT: cmd.op = OP_ROOT;
			S_PINIT: cmd.op = OP_PINIT;
			S_PX: cmd.op = status.mb_zero ? OP_QINIT : OP_MUL;
			S_QY: cmd.op = status.mb_zero ? OP_QSAVE : OP_MUL;
			S_CHECK: begin
				if (status.outside) begin
					cmd.op     = OP_STOP;
					cmd.reason = REASON_LEFT;
				end else begin
					cmd.op = OP_READ;
				end
			end
			S_TEST: begin
				if (status.obstacle) begin
					cmd.op     = OP_STOP;
					cmd.reason = REASON_OBST;
				end else if (status.at_end) begin
					cmd.op     = OP_STOP;
					cmd.reason = REASON_END;
				end else begin
					cmd.op = OP_STEP;
				end
			end
			S_SCALE: cmd.op = status.mb_zero ? OP_DIVINIT : OP_MUL;
			S_DIV: cmd.op = OP_DIV;
			S_CSINIT: cmd.op = OP_CSINIT;
			S_CSMUL: cmd.op = status.mb_zero ? OP_NONE : OP_MUL;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op   = OP_OUT;
					load_out = 1'b1;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/grt_dp.sv @@
`timescale 1ns / 1ps
// datapath of the grid ray traversal core: setup, shared shift-add multiplier,
// root and divide steps, cell walker, config and result registers; uses grt_pkg

module grt_dp #(
	parameter int GRID_WIDTH = 256,
	parameter int GRID_HEIGHT = 256,
	parameter int FRACTION_BITS = 16,
	localparam int GAW = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  grt_pkg::cmd_t      cmd,
	output grt_pkg::status_t   status,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [7:0]         cell_x,
	input  logic [7:0]         cell_y,
	input  logic signed [7:0]  cell_value,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	output logic [31:0]        distance,
	output logic [1:0]         stop_reason,
	output logic               ram_we,
	output logic [GAW-1:0]     ram_waddr,
	output logic [7:0]         ram_wdata,
	output logic               ram_re,
	output logic [GAW-1:0]     ram_raddr,
	input  logic [7:0]         ram_rdata
);
	import grt_pkg::*;

	localparam int F     = FRACTION_BITS;
	localparam int NW    = F + $clog2(GRID_WIDTH + GRID_HEIGHT + 2) + 1;
	localparam int PW    = NW + 33;
	localparam int DW    = NW + ROOT_W;
	localparam int MW    = DW + 32;
	localparam int MBW   = (NW > 33) ? NW : 33;
	localparam int RW    = 37;
	localparam int CELLW = 32 - F;
	localparam int CW    = CELLW + 1;
	localparam int NCW   = CW + 1;
	localparam int GMAX  = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
	localparam int GB    = $clog2(GMAX) + 1;
	localparam int XW    = ((CW > GB) ? CW : GB) + 1;
	localparam int XB    = $clog2(GRID_WIDTH);
	localparam int YB    = $clog2(GRID_HEIGHT);
	localparam int CNTW  = $clog2(DW + 1);
	localparam logic [F:0] UNIT = (F + 1)'(1) << F;

	// ray setup
	logic [32:0]             dx_q, dy_q;
	logic                    xneg_q, yneg_q;
	logic signed [XW-1:0]    cx_q, cy_q;
	logic [NCW-1:0]          n_q;
	logic [NW-1:0]           nx_q, ny_q, tnum_q;
	logic [32:0]             tden_q;
	logic [PW-1:0]           p_q, q_q;
	// shared arithmetic
	logic [ROOT_W-1:0]       root_q;
	logic [RW-1:0]           rem_q;
	logic [MW-1:0]           acc_q, ma_q;
	logic [MBW-1:0]          mb_q;
	logic [CNTW-1:0]         cnt_q;
	stop_t                   reason_q, outreason_q;
	logic [31:0]             dist_q;
	// config
	logic signed [7:0]       thr_q;
	logic [31:0]             cs_q;

	logic signed [32:0]      diffx, diffy;
	logic [32:0]             dxa, dya;
	logic                    xpos, ypos;
	logic signed [CELLW-1:0] scx, scy, ecx, ecy;
	logic signed [CW-1:0]    cdx, cdy, xcnt, ycnt;
	logic [NCW-1:0]          n0;
	logic [F:0]              nx0, ny0;
	logic [RW-1:0]           rem_sq, trial, rem_dv, den;
	logic                    sq_ge, dv_ge, ydo, sat;

	always_comb begin
		diffx = {end_x[31], end_x} - {start_x[31], start_x};
		diffy = {end_y[31], end_y} - {start_y[31], start_y};
		dxa   = diffx[32] ? unsigned'(-diffx) : unsigned'(diffx);
		dya   = diffy[32] ? unsigned'(-diffy) : unsigned'(diffy);
		xpos  = !diffx[32] && (diffx != '0);
		ypos  = !diffy[32] && (diffy != '0);
		scx   = start_x[31:F];
		scy   = start_y[31:F];
		ecx   = end_x[31:F];
		ecy   = end_y[31:F];
		cdx   = CW'(ecx) - CW'(scx);
		cdy   = CW'(ecy) - CW'(scy);
		xcnt  = (dxa == '0) ? '0 : (xpos ? cdx : -cdx);
		ycnt  = (dya == '0) ? '0 : (ypos ? cdy : -cdy);
		n0    = NCW'(1) + {1'b0, unsigned'(xcnt)} + {1'b0, unsigned'(ycnt)};
		nx0   = (dxa == '0) ? '0 : (xpos ? UNIT - {1'b0, start_x[F-1:0]}
		                                 : {1'b0, start_x[F-1:0]});
		ny0   = (dya == '0) ? '0 : (ypos ? UNIT - {1'b0, start_y[F-1:0]}
		                                 : {1'b0, start_y[F-1:0]});
	end

	// two radicand bits per root step, one dividend bit per divide step
	always_comb begin
		rem_sq = {rem_q[RW-3:0], acc_q[67:66]};
		trial  = RW'({root_q, 2'b01});
		sq_ge  = rem_sq >= trial;
		den    = RW'(tden_q);
		rem_dv = {rem_q[RW-2:0], acc_q[DW-1]};
		dv_ge  = rem_dv >= den;
		ydo    = (dy_q != '0) && ((dx_q == '0) || (p_q < q_q));
		sat    = |acc_q[MW-1:F+32];
	end

	always_comb begin
		status.mb_zero  = (mb_q == '0);
		status.cnt_last = (cnt_q == CNTW'(1));
		status.outside  = (cx_q < 0) || (cx_q >= XW'(GRID_WIDTH))
		               || (cy_q < 0) || (cy_q >= XW'(GRID_HEIGHT));
		status.obstacle = $signed(ram_rdata) > thr_q;
		status.at_end   = (n_q <= NCW'(1));
	end

	always_comb begin
		ram_we    = (cmd.op == OP_MAPWR) && (int'(cell_x) < GRID_WIDTH)
		         && (int'(cell_y) < GRID_HEIGHT);
		ram_waddr = GAW'(int'(cell_y) * GRID_WIDTH + int'(cell_x));
		ram_wdata = cell_value;
		ram_re    = (cmd.op == OP_READ);
		ram_raddr = GAW'(int'(cy_q[YB-1:0]) * GRID_WIDTH + int'(cx_q[XB-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 8'sd50;
			cs_q  <= 32'd3277;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q <= cfg_data[7:0];
				REG_CELL_SIZE: cs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				dx_q   <= dxa;
				dy_q   <= dya;
				xneg_q <= !xpos;
				yneg_q <= !ypos;
				cx_q   <= XW'(scx);
				cy_q   <= XW'(scy);
				n_q    <= n0;
				nx_q   <= NW'(nx0);
				ny_q   <= NW'(ny0);
				tnum_q <= '0;
				tden_q <= 33'd1;
				acc_q  <= '0;
				ma_q   <= MW'(dxa);
				mb_q   <= MBW'(dxa);
			end
			OP_MUL: begin
				if (mb_q[0]) acc_q <= acc_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
			OP_LDDY: begin
				// dy squared accumulates on top of dx squared
				ma_q <= MW'(dy_q);
				mb_q <= MBW'(dy_q);
			end
			OP_ROOTINIT: begin
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNTW'(ROOT_STEPS);
			end
			OP_ROOT: begin
				rem_q  <= sq_ge ? rem_sq - trial : rem_sq;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				acc_q  <= acc_q << 2;
				cnt_q  <= cnt_q - CNTW'(1);
			end
			OP_PINIT: begin
				acc_q <= '0;
				ma_q  <= MW'(dx_q);
				mb_q  <= MBW'(ny_q);
			end
			OP_QINIT: begin
				p_q   <= acc_q[PW-1:0];
				acc_q <= '0;
				ma_q  <= MW'(dy_q);
				mb_q  <= MBW'(nx_q);
			end
			OP_QSAVE: q_q <= acc_q[PW-1:0];
			OP_STEP: begin
				// cross products track ny*dx and nx*dy, tie steps along x
				if (ydo) begin
					tnum_q <= ny_q;
					tden_q <= dy_q;
					ny_q   <= ny_q + NW'(UNIT);
					p_q    <= p_q + (PW'(dx_q) << F);
					cy_q   <= yneg_q ? cy_q - XW'(1) : cy_q + XW'(1);
				end else begin
					tnum_q <= nx_q;
					tden_q <= dx_q;
					nx_q   <= nx_q + NW'(UNIT);
					q_q    <= q_q + (PW'(dy_q) << F);
					cx_q   <= xneg_q ? cx_q - XW'(1) : cx_q + XW'(1);
				end
				n_q <= n_q - NCW'(1);
			end
			OP_STOP: begin
				reason_q <= cmd.reason;
				acc_q    <= '0;
				ma_q     <= MW'(root_q);
				if (cmd.reason == REASON_END) begin
					mb_q   <= MBW'(1);
					tden_q <= 33'd1;
				end else begin
					mb_q <= MBW'(tnum_q);
				end
			end
			OP_DIVINIT: begin
				rem_q <= '0;
				cnt_q <= CNTW'(DW);
			end
			OP_DIV: begin
				rem_q <= dv_ge ? rem_dv - den : rem_dv;
				acc_q <= {acc_q[MW-2:0], dv_ge};
				cnt_q <= cnt_q - CNTW'(1);
			end
			OP_CSINIT: begin
				acc_q <= '0;
				ma_q  <= MW'(acc_q[DW-1:0]);
				mb_q  <= MBW'(cs_q);
			end
			OP_OUT: begin
				dist_q      <= sat ? 32'hFFFF_FFFF : acc_q[F+31:F];
				outreason_q <= reason_q;
			end
			default: ;
		endcase
	end

	assign distance    = dist_q;
	assign stop_reason = outreason_q;

endmodule

@@ dv/grt_trace_checker.sv @@
`timescale 1ns / 1ps
// transaction checker for the grid ray traversal core: keeps its own map and
// registers, predicts each trace result and compares it with the output port
// depends on grt_pkg

module grt_trace_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               mode,
	input  logic [7:0]         cell_x,
	input  logic [7:0]         cell_y,
	input  logic signed [7:0]  cell_value,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [31:0]        distance,
	input  logic [1:0]         stop_reason,
	output int                 fails,
	output int                 hits_pending
);
	import grt_pkg::*;

	localparam int GW = 256;
	localparam int GH = 256;
	localparam logic [127:0] ONE_CELL = 128'd65536;

	typedef struct {
		logic [31:0] meters;
		stop_t       reason;
	} hit_t;

	logic signed [7:0] occ_map [0:GW*GH-1];
	logic signed [7:0] occ_limit;
	logic [31:0]       meters_per_cell;
	hit_t              hit_q [$];

	assign hits_pending = hit_q.size();

	function automatic logic [127:0] ray_length(logic [127:0] v);
		logic [127:0] r, c;
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= v) r = c;
		end
		return r;
	endfunction

	function automatic logic [31:0] scale_dist(logic [127:0] num, logic [127:0] den,
			logic [127:0] len);
		logic [127:0] q, r;
		q = (num * len) / den;
		r = (q * meters_per_cell) >> 16;
		return (r > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	function automatic hit_t trace_ray(longint sx, longint sy, longint ex, longint ey);
		longint cx, cy, fx1, fy1, n, xinc, yinc;
		logic [127:0] dx, dy, nx, ny, len, tnum, tden;
		hit_t h;
		dx = (ex >= sx) ? 128'(ex - sx) : 128'(sx - ex);
		dy = (ey >= sy) ? 128'(ey - sy) : 128'(sy - ey);
		cx = sx >>> 16;
		cy = sy >>> 16;
		fx1 = ex >>> 16;
		fy1 = ey >>> 16;
		len = ray_length(dx * dx + dy * dy);
		tnum = 0;
		tden = 1;
		nx = 0;
		ny = 0;
		xinc = 0;
		yinc = 0;
		n = 1;
		if (dx != 0) begin
			if (ex > sx) begin
				xinc = 1; n += fx1 - cx; nx = ONE_CELL - 128'(sx & 'hFFFF);
			end else begin
				xinc = -1; n += cx - fx1; nx = 128'(sx & 'hFFFF);
			end
		end
		if (dy != 0) begin
			if (ey > sy) begin
				yinc = 1; n += fy1 - cy; ny = ONE_CELL - 128'(sy & 'hFFFF);
			end else begin
				yinc = -1; n += cy - fy1; ny = 128'(sy & 'hFFFF);
			end
		end
		forever begin
			if (cx < 0 || cx >= GW || cy < 0 || cy >= GH) begin
				h.meters = scale_dist(tnum, tden, len);
				h.reason = REASON_LEFT;
				return h;
			end
			if (occ_map[cy * GW + cx] > occ_limit) begin
				h.meters = scale_dist(tnum, tden, len);
				h.reason = REASON_OBST;
				return h;
			end
			if (n <= 1) begin
				h.meters = scale_dist(1, 1, len);
				h.reason = REASON_END;
				return h;
			end
			// a tie between the crossings goes to the x step
			if (dy != 0 && (dx == 0 || ny * dx < nx * dy)) begin
				tnum = ny; tden = dy; ny += ONE_CELL; cy += yinc;
			end else begin
				tnum = nx; tden = dx; nx += ONE_CELL; cx += xinc;
			end
			n--;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hit_t h;
		if (!arst_n) begin
			occ_limit = 8'sd50;
			meters_per_cell = 32'd3277;
			fails = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_THRESHOLD) occ_limit = cfg_data[7:0];
				else meters_per_cell = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (mode == 1'b0) occ_map[cell_y * GW + cell_x] = cell_value;
				else hit_q.push_back(trace_ray(start_x, start_y, end_x, end_y));
			end
			if (out_valid && out_ready) begin
				if (hit_q.size() == 0) begin
					$error("unexpected result transaction: distance %0h reason %0d",
						distance, stop_reason);
					fails = fails + 1;
				end else begin
					h = hit_q.pop_front();
					if (distance !== h.meters) begin
						$error("distance: expected %0h, actual %0h", h.meters, distance);
						fails = fails + 1;
					end
					if (stop_reason !== h.reason) begin
						$error("stop_reason: expected %0d, actual %0d", h.reason,
							stop_reason);
						fails = fails + 1;
					end
				end
			end
		end
	end

endmodule

@@ dv/tb_grid_ray_traversal_core.sv @@
`timescale 1ns / 1ps
// testbench top for the grid ray traversal core: loads a walled corner of the
// map, then runs directed and random rays over several register settings
// depends on grt_pkg, grid_ray_traversal_core and grt_trace_checker

module tb_grid_ray_traversal_core;
	import grt_pkg::*;

	// rays start in cells -3..REGION or off the map, the row and column REGION are walls
	localparam int REGION = 15;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic               cfg_index = REG_THRESHOLD;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               mode = 1'b0;
	logic [7:0]         cell_x = '0;
	logic [7:0]         cell_y = '0;
	logic signed [7:0]  cell_value = '0;
	logic signed [31:0] start_x = '0;
	logic signed [31:0] start_y = '0;
	logic signed [31:0] end_x = '0;
	logic signed [31:0] end_y = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        distance;
	logic [1:0]         stop_reason;
	int                 fails;
	int                 hits_pending;
	bit                 gaps_on = 1'b0;
	bit                 hold_req = 1'b0;

	always #6 clk = ~clk;

	grid_ray_traversal_core u_top (.*);

	grt_trace_checker u_chk (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready = (pick_gap() == 0);
		end
	end

	task automatic send(logic m, logic [7:0] x, logic [7:0] y, logic [7:0] v,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
		repeat (pick_gap()) @(negedge clk);
		mode = m; cell_x = x; cell_y = y; cell_value = v;
		start_x = sx; start_y = sy; end_x = ex; end_y = ey;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic map_write(int x, int y, logic [7:0] v);
		send(1'b0, x[7:0], y[7:0], v, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic trace(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
			logic [31:0] ey);
		send(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), sx, sy, ex, ey);
	endtask

	task automatic write_reg(logic idx, logic [31:0] d);
		@(negedge clk);
		cfg_write = 1'b1; cfg_index = idx; cfg_data = d;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic drain();
		while (hits_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_occ();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 8'($urandom);
		if (r < 80) return 8'($signed($urandom_range(0, 31)) - 1);
		return 8'($urandom_range(31, 100));
	endfunction

	function automatic logic [31:0] at_cell(int c, bit exact);
		return 32'(c * 65536) | (exact ? 32'd0 : 32'($urandom_range(0, 65535)));
	endfunction

	// a start lies in the written corner or off the map
	function automatic logic [31:0] pick_start();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7FFF_FFFF;
		return at_cell(int'($urandom_range(0, REGION + 3)) - 3, r < 6);
	endfunction

	function automatic logic [31:0] pick_end(int near);
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) return $urandom;
		if (r == 1) return 32'h8000_0000;
		if (r == 2) return 32'h7FFF_FFFF;
		return at_cell(near + int'($urandom_range(0, 60)) - 30, r < 8);
	endfunction

	task automatic random_ray();
		logic [31:0] sx, sy, ex, ey;
		int r;
		sx = pick_start();
		sy = pick_start();
		ex = pick_end($signed(sx) >>> 16);
		ey = pick_end($signed(sy) >>> 16);
		r = $urandom_range(0, 19);
		if (r == 0) begin ex = sx; ey = sy; end
		else if (r < 3) ex = sx;
		else if (r < 5) ey = sy;
		trace(sx, sy, ex, ey);
	endtask

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [31:0] limits [6];
		logic [31:0] sizes [6];
		limits = '{32'd50, 32'hFFFF_FFFF, 32'd100, 32'h1234_5600 | 32'd30, 32'd0, 32'd75};
		sizes = '{32'd3277, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'd7, 32'h0FFF_0000};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill the corner and wall it off so no walk reaches an unwritten cell
		for (int y = 0; y <= REGION; y++)
			for (int x = 0; x <= REGION; x++)
				map_write(x, y, (x == REGION || y == REGION) ? 8'sd127 : pick_occ());
		gaps_on = 1'b1;

		// directed cases
		map_write(0, 0, 8'sd100);
		map_write(14, 14, -8'sd1);
		map_write(8, 8, 8'sh80);
		map_write(9, 8, 8'sh7F);
		trace(at_cell(2, 1'b1), at_cell(8, 1'b1) | 32'h8000, at_cell(12, 1'b1),
			at_cell(8, 1'b1) | 32'h8000);
		trace(at_cell(1, 1'b1) | 32'h8000, at_cell(1, 1'b1) | 32'h8000,
			at_cell(11, 1'b1) | 32'h8000, at_cell(11, 1'b1) | 32'h8000);
		trace(at_cell(5, 1'b1) | 32'h4000, at_cell(12, 1'b1), at_cell(5, 1'b1) | 32'h4000,
			at_cell(2, 1'b1));
		trace(at_cell(1, 1'b1), at_cell(7, 1'b1) | 32'h1, at_cell(200, 1'b1),
			at_cell(7, 1'b1) | 32'h1);
		trace(at_cell(10, 1'b1), at_cell(10, 1'b1), at_cell(4, 1'b1),
			at_cell(3, 1'b1) | 32'h10);
		trace(at_cell(7, 1'b1) | 32'h3333, at_cell(9, 1'b1) | 32'h3333,
			at_cell(7, 1'b1) | 32'h3333, at_cell(9, 1'b1) | 32'h3333);
		trace(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		trace(at_cell(6, 1'b1), at_cell(6, 1'b1), 32'h7FFF_FFFF, 32'h8000_0000);
		trace(at_cell(3, 1'b1), at_cell(12, 1'b1), 32'h8000_0000, 32'h7FFF_FFFF);
		trace(at_cell(0, 1'b1), at_cell(0, 1'b1), at_cell(14, 1'b1) | 32'hFFFF,
			at_cell(14, 1'b1) | 32'hFFFF);
		trace(at_cell(-1, 1'b1) | 32'hFFFF, at_cell(2, 1'b1), at_cell(10, 1'b1),
			at_cell(3, 1'b1));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_THRESHOLD, limits[ph]);
			write_reg(REG_CELL_SIZE, sizes[ph]);
			if (ph == 2) hold_req = 1'b1;
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(0, 99) < 30)
					map_write($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
						pick_occ());
				else
					random_ray();
			end
			drain();
		end

		repeat (200) @(negedge clk);
		if (fails == 0 && hits_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ grid_ray_traversal_core.f @@
design/grt_pkg.sv
design/grt_ram.sv
design/grt_ctrl.sv
design/grt_dp.sv
design/grid_ray_traversal_core.sv
dv/grt_trace_checker.sv
dv/tb_grid_ray_traversal_core.sv
